@@ hdl/rrbq_pkg.sv @@
// shared constants and helpers for the round robin burst queue
package rrbq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;

   localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS = TIME_BITS + CNT_BITS;

   localparam int KIND_BITS   = 3;
   localparam int STATUS_BITS = 2;
   localparam int VALUE_BITS  = 16;
   localparam int TOTAL_BITS  = 20;
   localparam int QUANT_BITS  = 16;
   localparam int CMP_BITS    = 33;

   localparam logic [QUANT_BITS-1:0] QUANTUM_RESET = QUANT_BITS'(5);
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX     = '1;

   // command kinds
   localparam logic [KIND_BITS-1:0] KIND_ENQUEUE = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_DEQUEUE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_FRONT   = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_REAR    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_TOTAL   = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_PASS    = 3'd5;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   function automatic logic [IDX_BITS-1:0] next_index(input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS-1:0] res;
      if (idx == IDX_BITS'(QUEUE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_BITS'(1);
      end
      return res;
   endfunction

   function automatic logic [IDX_BITS-1:0] prev_index(input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS-1:0] res;
      if (idx == '0) begin
         res = IDX_BITS'(QUEUE_DEPTH - 1);
      end else begin
         res = idx - IDX_BITS'(1);
      end
      return res;
   endfunction

   function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [SUM_BITS-1:0] s);
      logic [63:0] wide;
      logic [TOTAL_BITS-1:0] res;
      wide = 64'(s);
      if (wide > 64'(TOTAL_MAX)) begin
         res = TOTAL_MAX;
      end else begin
         res = TOTAL_BITS'(wide);
      end
      return res;
   endfunction

endpackage

@@ hdl/round_robin_burst_queue.sv @@
// round robin burst queue: bounded fifo of task times with round robin passes
//
// commands come in on the req_ channel (req_kind, req_burst_value) as one beat
// each; results leave on the rsp_ channel, one beat per command, except a round
// robin pass, which gives one beat per queued entry (head to tail, rsp_last on
// the tail entry) or a single empty-status beat on an empty queue.
// the user must write the quantum through csr_write_enable / csr_write_data
// only while idle; the block does not enforce it. timing: a command is taken
// in idle, reading the entry store on that edge; its result is computed in
// exec and registered into output. each further pass beat, one entry at a
// time, starts when the previous one is taken and goes through exec and
// output again, on one shared compare/subtract unit and the entry store's
// single read port. req_stall is high from acceptance until the command's
// last beat is taken. a stalled rsp beat holds; the sequencer waits in output.
// reset (synchronous, active high) empties the queue, clears the running sum
// and sets the quantum to 5; entry store contents are not cleared.
module round_robin_burst_queue
   import rrbq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [KIND_BITS-1:0]   req_kind,
   input  logic [VALUE_BITS-1:0]  req_burst_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [VALUE_BITS-1:0]  rsp_read_value,
   output logic [TOTAL_BITS-1:0]  rsp_total_time,
   output logic                   rsp_is_empty,
   output logic                   rsp_entry_done,
   output logic                   rsp_last,
   input  logic                   csr_write_enable,
   input  logic [QUANT_BITS-1:0]  csr_write_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   // control state
   logic [1:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   head_ff, head_in;
   logic [IDX_BITS-1:0]   tail_ff, tail_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [QUANT_BITS-1:0] quantum_ff;
   logic                  rsp_valid_ff, rsp_valid_in;

   // per-command working registers
   logic [KIND_BITS-1:0]  kind_ff;
   logic [TIME_BITS-1:0]  burst_ff;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_BITS-1:0]   remain_ff, remain_in;

   // result payload registers
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic                   empty_ff, empty_in;
   logic                   done_ff, done_in;
   logic                   last_ff, last_in;

   // entry store, one write port and one registered read port
   logic [TIME_BITS-1:0] store_mem [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] rd_data_ff;
   logic [IDX_BITS-1:0]  rd_addr;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [TIME_BITS-1:0] wr_data;

   // shared compare/subtract unit
   logic [CMP_BITS-1:0]  old_w, quant_w;
   logic                 over_quantum;
   logic [TIME_BITS-1:0] pass_value;
   logic [TIME_BITS-1:0] pass_cut;
   logic [TIME_BITS-1:0] sub_amount;
   logic [SUM_BITS-1:0]  sum_less;

   logic req_take;
   logic rsp_take;

   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = value_ff;
   assign rsp_total_time = total_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_entry_done = done_ff;
   assign rsp_last       = last_ff;

   // one entry through the quantum: above it loses a slice, otherwise done
   assign old_w        = CMP_BITS'(rd_data_ff);
   assign quant_w      = CMP_BITS'(quantum_ff);
   assign over_quantum = old_w > quant_w;
   assign pass_value   = over_quantum ? TIME_BITS'(old_w - quant_w) : '0;
   assign pass_cut     = rd_data_ff - pass_value;

   // the running sum loses either the removed entry or the slice cut off
   assign sub_amount = (kind_ff == KIND_DEQUEUE) ? rd_data_ff : pass_cut;
   assign sum_less   = (sum_ff >= SUM_BITS'(sub_amount)) ?
                       (sum_ff - SUM_BITS'(sub_amount)) : '0;

   // read address: head or last entry at accept, next entry between pass beats
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = (req_kind == KIND_REAR) ? prev_index(tail_ff) : head_ff;
      end else begin
         rd_addr = next_index(idx_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      idx_in       = idx_ff;
      remain_in    = remain_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      total_in     = total_ff;
      empty_in     = empty_ff;
      done_in      = done_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = burst_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               idx_in    = head_ff;
               remain_in = count_ff;
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in = STATUS_OK;
            value_in  = '0;
            done_in   = 1'b0;
            last_in   = 1'b1;
            case (kind_ff)
               KIND_ENQUEUE: begin
                  if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     tail_in  = next_index(tail_ff);
                     count_in = count_ff + CNT_BITS'(1);
                     sum_in   = sum_ff + SUM_BITS'(burst_ff);
                  end
               end
               KIND_DEQUEUE: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     value_in = VALUE_BITS'(rd_data_ff);
                     head_in  = next_index(head_ff);
                     count_in = count_ff - CNT_BITS'(1);
                     sum_in   = sum_less;
                  end
               end
               KIND_FRONT, KIND_REAR: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     value_in = VALUE_BITS'(rd_data_ff);
                  end
               end
               KIND_PASS: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = idx_ff;
                     wr_data  = pass_value;
                     sum_in   = sum_less;
                     value_in = VALUE_BITS'(pass_value);
                     done_in  = !over_quantum;
                     last_in  = (remain_ff == CNT_BITS'(1));
                  end
               end
               default: begin
                  // total query and unused kinds report the state only
               end
            endcase
            total_in     = sat_total(sum_in);
            empty_in     = (count_in == '0);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end

         ST_OUT: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // next pass beat; its entry is read on this edge
                  idx_in    = next_index(idx_ff);
                  remain_in = remain_ff - CNT_BITS'(1);
                  state_in  = ST_EXEC;
               end
            end
         end

         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         quantum_ff   <= QUANTUM_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            quantum_ff <= csr_write_data;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_kind;
         burst_ff <= TIME_BITS'(req_burst_value);
      end
      idx_ff    <= idx_in;
      remain_ff <= remain_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      total_ff  <= total_in;
      empty_ff  <= empty_in;
      done_ff   <= done_in;
      last_ff   <= last_in;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

endmodule
